// ===== rtl/teq_pkg.sv =====
package teq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam logic [2:0] FUNC_SCHEDULE   = 3'd0;
   localparam logic [2:0] FUNC_UNSCHEDULE = 3'd1;
   localparam logic [2:0] FUNC_REMOVE     = 3'd2;
   localparam logic [2:0] FUNC_ADVANCE    = 3'd3;
   localparam logic [2:0] FUNC_CLEAR      = 3'd4;

   localparam logic [2:0] KIND_FIRED = 3'd0;
   localparam logic [2:0] KIND_NEXT  = 3'd1;
   localparam logic [2:0] KIND_EMPTY = 3'd2;
   localparam logic [2:0] KIND_DONE  = 3'd3;
   localparam logic [2:0] KIND_FULL  = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       append;
      logic       clear_all;
      logic       idx_clr;
      logic       idx_inc;
      logic       drop_idx;
      logic       best_take;
      logic       drop_best;
      logic       load;
      logic [2:0] kind;
      logic       last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] func;
      logic       idx_end;
      logic       match;
      logic       full;
      logic       empty;
      logic       due_le_now;
      logic       out_busy;
   } stat_type;

endpackage

// ===== rtl/timed_event_queue_top.sv =====
// schedule, clear: the command is captured and dispatched, then its single result is loaded
// unschedule, remove: one scan over the stored entries drops every match, then one result
// advance: one scan per fired event and one final scan; one command at a time
// each scan reads one stored entry per cycle; rsp stalls hold the results back
// reset: synchronous, active high; empties the queue and zeroes the sequence counter
module timed_event_queue_top #(
   parameter int DEPTH = teq_pkg::DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // command channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [2:0]   req_tuser,  // func
   input  logic [199:0] req_tdata,  // now_ns, delay_ns, type_id, user_data
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [2:0]   rsp_tuser,  // kind
   output logic [199:0] rsp_tdata,  // fired_type, fired_data, lateness_ns, next_delay_ns
   output logic         rsp_tlast   // final result of a command
);

   // command and status between sequencer and queue datapath
   teq_pkg::cmd_type  cmd;
   teq_pkg::stat_type stat;

   // sequencer: dispatch, entry scans, result transfers
   teq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // storage, compare and result register
   teq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

// ===== rtl/teq_ctrl.sv =====
module teq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  teq_pkg::stat_type stat,
   output teq_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_FIND,
      ST_DECIDE,
      ST_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] kind_ff, kind_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      kind_in  = kind_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            kind_in  = teq_pkg::KIND_DONE;
            state_in = ST_OUT;
            case (stat.func)
               teq_pkg::FUNC_SCHEDULE: begin
                  if (stat.full) begin
                     kind_in = teq_pkg::KIND_FULL;
                  end else begin
                     cmd.append = 1'b1;
                  end
               end
               teq_pkg::FUNC_UNSCHEDULE, teq_pkg::FUNC_REMOVE: begin
                  cmd.idx_clr = 1'b1;
                  state_in    = ST_SCAN;
               end
               teq_pkg::FUNC_ADVANCE: begin
                  cmd.idx_clr = 1'b1;
                  state_in    = ST_FIND;
               end
               teq_pkg::FUNC_CLEAR: begin
                  cmd.clear_all = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            if (stat.idx_end) begin
               kind_in  = teq_pkg::KIND_DONE;
               state_in = ST_OUT;
            end else if (stat.match) begin
               cmd.drop_idx = 1'b1;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_FIND: begin
            if (stat.idx_end) begin
               state_in = ST_DECIDE;
            end else begin
               cmd.best_take = 1'b1;
               cmd.idx_inc   = 1'b1;
            end
         end
         ST_DECIDE: begin
            if (stat.empty) begin
               kind_in  = teq_pkg::KIND_EMPTY;
               state_in = ST_OUT;
            end else if (!stat.due_le_now) begin
               kind_in  = teq_pkg::KIND_NEXT;
               state_in = ST_OUT;
            end else if (!stat.out_busy) begin
               cmd.load      = 1'b1;
               cmd.kind      = teq_pkg::KIND_FIRED;
               cmd.drop_best = 1'b1;
               cmd.idx_clr   = 1'b1;
               state_in      = ST_FIND;
            end
         end
         ST_OUT: begin
            if (!stat.out_busy) begin
               cmd.load = 1'b1;
               cmd.kind = kind_ff;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= teq_pkg::KIND_DONE;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// ===== rtl/teq_datapath.sv =====
module teq_datapath #(
   parameter int DEPTH = teq_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [2:0]        req_tuser,
   input  logic [199:0]      req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [199:0]      rsp_tdata,
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast,
   input  teq_pkg::cmd_type  cmd,
   output teq_pkg::stat_type stat
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // queue storage, compacted so live entries sit below the count
   logic [63:0] due_ff [DEPTH];
   logic [63:0] seq_ff [DEPTH];
   logic [7:0]  typ_ff [DEPTH];
   logic [63:0] dat_ff [DEPTH];

   logic [CW-1:0] count_ff, count_in;
   logic [63:0]   next_seq_ff, next_seq_in;
   logic [CW-1:0] idx_ff, idx_in;

   // captured command
   logic [2:0]  func_ff;
   logic [63:0] now_ff, delay_ff, data_ff;
   logic [7:0]  type_ff;

   // earliest entry found so far
   logic [63:0] best_due_ff, best_seq_ff, best_dat_ff;
   logic [7:0]  best_typ_ff;
   logic [CW-1:0] best_idx_ff;

   logic          rsp_valid_ff;
   logic [199:0]  rsp_data_ff, rsp_data_in;
   logic [2:0]    rsp_kind_ff;
   logic          rsp_last_ff;

   logic [IW-1:0] rd_idx;
   logic [63:0]   rd_due, rd_seq, rd_dat;
   logic [7:0]    rd_typ;
   logic          earlier;
   logic          drop;
   logic [CW-1:0] drop_pos;

   assign rd_idx = idx_ff[IW-1:0];
   assign rd_due = due_ff[rd_idx];
   assign rd_seq = seq_ff[rd_idx];
   assign rd_typ = typ_ff[rd_idx];
   assign rd_dat = dat_ff[rd_idx];

   assign earlier = (idx_ff == '0) || (rd_due < best_due_ff) ||
                    ((rd_due == best_due_ff) && (rd_seq < best_seq_ff));

   assign drop     = cmd.drop_idx || cmd.drop_best;
   assign drop_pos = cmd.drop_best ? best_idx_ff : idx_ff;

   always_comb begin
      stat.func       = func_ff;
      stat.idx_end    = (idx_ff >= count_ff);
      stat.match      = (rd_typ == type_ff) &&
                        ((func_ff != teq_pkg::FUNC_UNSCHEDULE) || (rd_dat == data_ff));
      stat.full       = (count_ff >= CW'(DEPTH));
      stat.empty      = (count_ff == '0);
      stat.due_le_now = (best_due_ff <= now_ff);
      stat.out_busy   = rsp_valid_ff && !rsp_tready;
   end

   always_comb begin
      count_in    = count_ff;
      next_seq_in = next_seq_ff;
      idx_in      = idx_ff;
      if (cmd.append) begin
         count_in    = count_ff + CW'(1);
         next_seq_in = next_seq_ff + 64'd1;
      end
      if (drop) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.clear_all) begin
         count_in = '0;
      end
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CW'(1);
      end
   end

   // result fields, unused ones left at zero
   always_comb begin
      rsp_data_in = '0;
      if (cmd.kind == teq_pkg::KIND_FIRED) begin
         rsp_data_in[7:0]    = best_typ_ff;
         rsp_data_in[71:8]   = best_dat_ff;
         rsp_data_in[135:72] = now_ff - best_due_ff;
      end else if (cmd.kind == teq_pkg::KIND_NEXT) begin
         rsp_data_in[199:136] = best_due_ff - now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         next_seq_ff  <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         next_seq_ff <= next_seq_in;
         idx_ff      <= idx_in;
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DEPTH; j++) begin
         if (cmd.append && (count_ff == CW'(j))) begin
            due_ff[j] <= now_ff + delay_ff;
            seq_ff[j] <= next_seq_ff;
            typ_ff[j] <= type_ff;
            dat_ff[j] <= data_ff;
         end else if (drop && (j < DEPTH - 1) && (CW'(j) >= drop_pos)) begin
            due_ff[j] <= due_ff[(j + 1) % DEPTH];
            seq_ff[j] <= seq_ff[(j + 1) % DEPTH];
            typ_ff[j] <= typ_ff[(j + 1) % DEPTH];
            dat_ff[j] <= dat_ff[(j + 1) % DEPTH];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_tuser;
         now_ff   <= req_tdata[63:0];
         delay_ff <= req_tdata[127:64];
         type_ff  <= req_tdata[135:128];
         data_ff  <= req_tdata[199:136];
      end
      if (cmd.best_take && earlier) begin
         best_due_ff <= rd_due;
         best_seq_ff <= rd_seq;
         best_typ_ff <= rd_typ;
         best_dat_ff <= rd_dat;
         best_idx_ff <= idx_ff;
      end
      if (cmd.load) begin
         rsp_kind_ff <= cmd.kind;
         rsp_last_ff <= cmd.last;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
